// ----- rtl/ppmd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared types and constants of the PPM pulse decoder.
// ----------------------------------------------------------------------------
package ppmd_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int COUNT_BITS_DEF   = 24;
	localparam int FULL_SCALE_DEF   = 8192;

	localparam int REG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int VAL_W   = 14;
	localparam int Q_FRAC  = 20;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [REG_W-1:0] SYNC_TICKS_RST   = REG_W'(625000);
	localparam logic [REG_W-1:0] MIN_TICKS_RST    = REG_W'(50000);
	localparam logic [REG_W-1:0] MAX_TICKS_RST    = REG_W'(256250);
	localparam logic [REG_W-1:0] SCALE_FACTOR_RST = REG_W'(41648);

	typedef enum logic [1:0] {
		REG_SYNC  = 2'd0,
		REG_MIN   = 2'd1,
		REG_MAX   = 2'd2,
		REG_SCALE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] sync_ticks;
		logic [REG_W-1:0] min_ticks;
		logic [REG_W-1:0] max_ticks;
		logic [REG_W-1:0] scale_factor;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             last;
	} chan_t;

endpackage

// ----- rtl/ppm_pulse_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ppm_pulse_decoder_top
// RC PPM stream decoder: one line sample in, channel index and value out.
//
// Input: one pin_level sample per transaction, taken when push is high and
// full is low. The front end detects edges, counts ticks of each low pulse,
// tracks frame sync and passes channel pulses into a two-entry queue.
// Output: one transaction per channel pulse, offered while empty is low and
// taken when pop is high. Most samples produce no result.
// Throughput: one sample every cycle; full rises only when the queue between
// front and back end is full, which happens only while pop is held low.
// Path: the sample that ends a pulse writes the queue on the accepting edge;
// the result then passes the clamp and offset stage, the multiplier stage
// and the output register.
// Reset clears sync, counter and queues and loads the register defaults;
// a stalled result holds on the output ports until popped.
// Registers on the APB port: 0x0 sync_ticks, 0x4 min_ticks, 0x8 max_ticks,
// 0xC scale_factor; write only while idle.
// ----------------------------------------------------------------------------
module ppm_pulse_decoder_top #(
	parameter int NUM_CHANNELS = ppmd_pkg::NUM_CHANNELS_DEF,
	parameter int COUNT_BITS   = ppmd_pkg::COUNT_BITS_DEF,
	parameter int FULL_SCALE   = ppmd_pkg::FULL_SCALE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         pin_level,
	output logic                         empty,
	input  logic                         pop,
	output logic [ppmd_pkg::IDX_W-1:0]  channel_index,
	output logic [ppmd_pkg::VAL_W-1:0]  channel_value,
	output logic                         frame_last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppmd_pkg::ADDR_W-1:0] paddr,
	input  logic [ppmd_pkg::DATA_W-1:0] pwdata,
	output logic [ppmd_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);
	import ppmd_pkg::*;

	localparam int Q_W = COUNT_BITS + $bits(chan_t);

	cfg_t                  cfg_q;
	reg_idx_t              reg_sel;
	logic                  wr_en, accept;
	logic                  f_push, q_valid, q_take;
	chan_t                 f_chan, q_chan;
	logic [COUNT_BITS-1:0] f_width, q_width;
	logic [Q_W-1:0]        q_rd;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_SYNC:  prdata = DATA_W'(cfg_q.sync_ticks);
			REG_MIN:   prdata = DATA_W'(cfg_q.min_ticks);
			REG_MAX:   prdata = DATA_W'(cfg_q.max_ticks);
			REG_SCALE: prdata = DATA_W'(cfg_q.scale_factor);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_ticks   <= SYNC_TICKS_RST;
			cfg_q.min_ticks    <= MIN_TICKS_RST;
			cfg_q.max_ticks    <= MAX_TICKS_RST;
			cfg_q.scale_factor <= SCALE_FACTOR_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SYNC:  cfg_q.sync_ticks   <= pwdata[REG_W-1:0];
				REG_MIN:   cfg_q.min_ticks    <= pwdata[REG_W-1:0];
				REG_MAX:   cfg_q.max_ticks    <= pwdata[REG_W-1:0];
				REG_SCALE: cfg_q.scale_factor <= pwdata[REG_W-1:0];
				default:   ;
			endcase
		end
	end

	assign accept = push && !full;

	ppmd_front #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNT_BITS   (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.pin_level  (pin_level),
		.cfg        (cfg_q),
		.item_push  (f_push),
		.item_chan  (f_chan),
		.item_width (f_width)
	);

	ppmd_fifo #(
		.WIDTH (Q_W),
		.DEPTH (2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data ({f_chan, f_width}),
		.full    (full),
		.rd_en   (q_take),
		.rd_data (q_rd),
		.valid   (q_valid)
	);

	assign q_chan  = q_rd[Q_W-1:COUNT_BITS];
	assign q_width = q_rd[COUNT_BITS-1:0];

	ppmd_back #(
		.COUNT_BITS (COUNT_BITS),
		.FULL_SCALE (FULL_SCALE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (q_valid),
		.in_chan       (q_chan),
		.in_width      (q_width),
		.in_take       (q_take),
		.empty         (empty),
		.pop           (pop),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.frame_last    (frame_last)
	);
endmodule

// ----- rtl/ppmd_fifo.sv -----
// ----------------------------------------------------------------------------
// ppmd_fifo
// Short synchronous queue between the pulse front end and the scaling back end.
// ----------------------------------------------------------------------------
module ppmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ----- rtl/ppmd_front.sv -----
// ----------------------------------------------------------------------------
// ppmd_front
// Edge detection, tick counting, sync tracking and channel pulse selection.
// ----------------------------------------------------------------------------
module ppmd_front #(
	parameter int NUM_CHANNELS = 8,
	parameter int COUNT_BITS   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  pin_level,
	input  ppmd_pkg::cfg_t        cfg,
	output logic                  item_push,
	output ppmd_pkg::chan_t       item_chan,
	output logic [COUNT_BITS-1:0] item_width
);
	import ppmd_pkg::*;

	localparam int POS_BITS = $clog2(NUM_CHANNELS + 2) + 1;
	localparam int CMP_W    = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
	localparam logic signed [POS_BITS-1:0] POS_NOSYNC = -2;
	localparam logic signed [POS_BITS-1:0] POS_SYNC   = -1;

	logic                       prev_q;
	logic [COUNT_BITS-1:0]      cnt_q;
	logic                       ovf_q;
	logic signed [POS_BITS-1:0] pos_q;

	logic                  fall, rise, wrap, ovf_next, pos_adv, pos_chan;
	logic [COUNT_BITS-1:0] cnt_next;

	assign fall     = prev_q && !pin_level;
	assign rise     = !prev_q && pin_level;
	assign wrap     = (cnt_q == {COUNT_BITS{1'b1}});
	assign cnt_next = wrap ? '0 : cnt_q + 1'b1;
	assign ovf_next = ovf_q || wrap;
	assign pos_adv  = (pos_q >= -1) && (pos_q <= NUM_CHANNELS);
	assign pos_chan = (pos_q >= 0) && (pos_q < NUM_CHANNELS);

	assign item_push = accept && rise && !ovf_next && pos_chan
		&& !(CMP_W'(cnt_next) > CMP_W'(cfg.sync_ticks));
	assign item_chan.index = IDX_W'($unsigned(pos_q));
	assign item_chan.last  = (pos_q == NUM_CHANNELS - 1);
	assign item_width      = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			pos_q  <= POS_NOSYNC;
		end else if (accept) begin
			prev_q <= pin_level;
			if (fall) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				if (pos_adv) begin
					pos_q <= pos_q + 1'b1;
				end
			end else begin
				cnt_q <= cnt_next;
				ovf_q <= ovf_next;
				if (rise) begin
					if (ovf_next) begin
						pos_q <= POS_NOSYNC;
					end else if (CMP_W'(cnt_next) > CMP_W'(cfg.sync_ticks)) begin
						pos_q <= POS_SYNC;
					end
				end
			end
		end
	end
endmodule

// ----- rtl/ppmd_back.sv -----
// ----------------------------------------------------------------------------
// ppmd_back
// Clamp, offset, Q4.20 scale and saturate channel widths; hold the result.
// ----------------------------------------------------------------------------
module ppmd_back #(
	parameter int COUNT_BITS = 24,
	parameter int FULL_SCALE = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppmd_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	input  ppmd_pkg::chan_t             in_chan,
	input  logic [COUNT_BITS-1:0]       in_width,
	output logic                        in_take,
	output logic                        empty,
	input  logic                        pop,
	output logic [ppmd_pkg::IDX_W-1:0] channel_index,
	output logic [ppmd_pkg::VAL_W-1:0] channel_value,
	output logic                        frame_last
);
	import ppmd_pkg::*;

	localparam int WB   = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
	localparam int PR_W = WB + REG_W;
	localparam int SH_W = PR_W - Q_FRAC;

	logic            v_s1, v_s2, v_s3;
	chan_t           chan_s1, chan_s2;
	logic [WB-1:0]   diff_s1;
	logic [PR_W-1:0] prod_s2;

	logic          rdy1, rdy2, rdy3;
	logic [WB-1:0] w, lo, hi, c_lo, c_hi, diff;
	logic [SH_W-1:0] shifted;
	logic [VAL_W-1:0] value;

	assign rdy3 = !v_s3 || pop;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_take = in_valid && rdy1;

	assign w    = WB'(in_width);
	assign lo   = WB'(cfg.min_ticks);
	assign hi   = WB'(cfg.max_ticks);
	assign c_lo = (w < lo) ? lo : w;
	assign c_hi = (c_lo > hi) ? hi : c_lo;
	assign diff = (c_hi >= lo) ? c_hi - lo : '0;

	assign shifted = prod_s2[PR_W-1:Q_FRAC];
	assign value   = (shifted > SH_W'(FULL_SCALE)) ? VAL_W'(FULL_SCALE)
		: shifted[VAL_W-1:0];

	assign empty = !v_s3;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			diff_s1 <= diff;
			chan_s1 <= in_chan;
		end
		if (rdy2 && v_s1) begin
			prod_s2 <= PR_W'(diff_s1) * PR_W'(cfg.scale_factor);
			chan_s2 <= chan_s1;
		end
		if (rdy3 && v_s2) begin
			channel_index <= chan_s2.index;
			frame_last    <= chan_s2.last;
			channel_value <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end
endmodule

// ----- sim/tb_ppm_pulse_decoder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ppm_pulse_decoder_top
// Self-checking bench for the PPM pulse decoder.
//
// Line samples are queued as PPM frames and driven one per transaction on the
// push side. Each accepted sample also goes through a local pulse decoder that
// tracks edges, tick count and frame slot, and queues the channel result it
// expects. The pop side compares every result, field by field, with the
// oldest queued expectation. Register writes over APB happen only once the
// decoder has drained. The run covers out-of-frame pulses, sync in mid-frame,
// clamping at both limits, inverted limits, zero and full-range scaling, and
// saturation at full scale.
// ----------------------------------------------------------------------------
module tb_ppm_pulse_decoder_top;
	import ppmd_pkg::*;

	localparam int CHANNELS   = NUM_CHANNELS_DEF;
	localparam int CNT_W      = COUNT_BITS_DEF;
	localparam int FULL_VALUE = FULL_SCALE_DEF;
	localparam int SETTLE     = 8;

	typedef struct {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             last;
	} chan_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              push      = 1'b0;
	logic              full;
	logic              pin_level = 1'b1;
	logic              empty;
	logic              pop       = 1'b0;
	logic [IDX_W-1:0]  channel_index;
	logic [VAL_W-1:0]  channel_value;
	logic              frame_last;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic         pending_levels[$];
	chan_result_t results_due[$];
	int           samples_queued = 0;
	int           samples_taken  = 0;
	int           mismatches     = 0;
	int           send_idle_pct  = 38;
	int           recv_idle_pct  = 60;

	cfg_t             model_cfg  = '{SYNC_TICKS_RST, MIN_TICKS_RST, MAX_TICKS_RST,
		SCALE_FACTOR_RST};
	logic             line_prev  = 1'b1;
	logic [CNT_W-1:0] ticks      = '0;
	logic             wrapped    = 1'b0;
	int               frame_slot = -2;

	ppm_pulse_decoder_top #(
		.NUM_CHANNELS(CHANNELS),
		.COUNT_BITS  (CNT_W),
		.FULL_SCALE  (FULL_VALUE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pin_level    (pin_level),
		.empty        (empty),
		.pop          (pop),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.frame_last   (frame_last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [VAL_W-1:0] scaled_width(logic [REG_W-1:0] width);
		logic [REG_W-1:0]   clamped;
		logic [REG_W-1:0]   above_min;
		logic [2*REG_W-1:0] prod;
		clamped = (width < model_cfg.min_ticks) ? model_cfg.min_ticks : width;
		if (clamped > model_cfg.max_ticks) begin
			clamped = model_cfg.max_ticks;
		end
		above_min = (clamped >= model_cfg.min_ticks) ? clamped - model_cfg.min_ticks : '0;
		prod = above_min * model_cfg.scale_factor;
		prod = prod >> Q_FRAC;
		if (prod > FULL_VALUE) begin
			return VAL_W'(FULL_VALUE);
		end
		return prod[VAL_W-1:0];
	endfunction

	function automatic void decode_sample(logic level);
		chan_result_t res;
		if (line_prev && !level) begin
			ticks = '0;
			wrapped = 1'b0;
			if (frame_slot >= -1 && frame_slot <= CHANNELS) begin
				frame_slot++;
			end
		end else begin
			if (ticks == '1) begin
				ticks = '0;
				wrapped = 1'b1;
			end else begin
				ticks++;
			end
			if (!line_prev && level) begin
				if (wrapped) begin
					frame_slot = -2;
				end else if (ticks > model_cfg.sync_ticks) begin
					frame_slot = -1;
				end else if (frame_slot >= 0 && frame_slot < CHANNELS) begin
					res.index = IDX_W'(frame_slot);
					res.value = scaled_width(ticks);
					res.last  = (frame_slot == CHANNELS - 1);
					results_due.push_back(res);
				end
			end
		end
		line_prev = level;
	endfunction

	always @(posedge clk) begin
		if (push && !full) begin
			decode_sample(pin_level);
			samples_taken++;
		end
		if (push && full) begin
			// hold the stalled transaction
		end else if (arst_n && pending_levels.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			push      <= 1'b1;
			pin_level <= pending_levels.pop_front();
		end else begin
			push <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		chan_result_t want;
		if (pop && !empty) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: index %0d value %0d last %0b",
						channel_index, channel_value, frame_last);
				end
			end else begin
				want = results_due.pop_front();
				if (channel_index !== want.index || channel_value !== want.value ||
						frame_last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected index %0d value %0d last %0b,",
							want.index, want.value, want.last,
							" got index %0d value %0d last %0b",
							channel_index, channel_value, frame_last);
					end
				end
			end
		end
		pop <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic int idle_gap();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
	endfunction

	task automatic add_pulse(int low_n, int high_n);
		repeat (low_n) pending_levels.push_back(1'b0);
		repeat (high_n) pending_levels.push_back(1'b1);
		samples_queued += low_n + high_n;
	endtask

	task automatic add_frame(int sync_len, int wmax);
		int chans;
		chans = $urandom_range(5, 10);
		if ($urandom_range(0, 7) != 0) begin
			add_pulse(sync_len + $urandom_range(1, 3), idle_gap());
		end
		repeat (chans) begin
			if ($urandom_range(0, 19) == 0) begin
				add_pulse(sync_len + 1, idle_gap());
			end else begin
				add_pulse($urandom_range(1, wmax), idle_gap());
			end
		end
	endtask

	task automatic drain_all();
		while (samples_taken != samples_queued || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {8'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SYNC:  model_cfg.sync_ticks   = val;
			REG_MIN:   model_cfg.min_ticks    = val;
			REG_MAX:   model_cfg.max_ticks    = val;
			REG_SCALE: model_cfg.scale_factor = val;
			default:   ;
		endcase
	endtask

	task automatic set_config(logic [REG_W-1:0] sync_t, logic [REG_W-1:0] min_t,
			logic [REG_W-1:0] max_t, logic [REG_W-1:0] scale);
		drain_all();
		write_reg(REG_SYNC, sync_t);
		write_reg(REG_MIN, min_t);
		write_reg(REG_MAX, max_t);
		write_reg(REG_SCALE, scale);
	endtask

	task automatic random_config();
		int sync_t;
		int min_t;
		sync_t = $urandom_range(6, 24);
		min_t  = $urandom_range(0, 8);
		set_config(REG_W'(sync_t), REG_W'(min_t), REG_W'($urandom_range(min_t, sync_t)),
			REG_W'($urandom()));
	endtask

	initial begin
		int dir_widths[10];
		dir_widths = '{1, 2, 3, 4, 5, 1, 1, 2, 1, 1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pulse before sync, sync, pulse at the minimum, clamp above, last channel, overrun
		set_config(REG_W'(5), REG_W'(1), REG_W'(3), '1);
		add_pulse(2, 1);
		add_pulse(6, 2);
		foreach (dir_widths[i]) add_pulse(dir_widths[i], 1);
		add_pulse(7, 1);

		set_config(REG_W'(16), REG_W'(3), REG_W'(12), REG_W'($urandom_range(24'h080000,
			24'h400000)));
		add_frame(16, 16);
		drain_all();
		add_frame(16, 16);

		// inverted limits
		set_config(REG_W'(12), REG_W'(10), REG_W'(4), REG_W'($urandom()));
		add_frame(12, 12);

		drain_all();
		send_idle_pct = 60;
		recv_idle_pct = 38;

		// every pulse is a sync; leaves the decoder in sync
		set_config('0, '0, '0, '0);
		repeat (4) add_pulse($urandom_range(1, 5), idle_gap());

		// full range, saturation just past 512 ticks
		set_config('1, '0, '1, '1);
		add_pulse(513, 1);
		repeat (3) add_pulse($urandom_range(1, 40), idle_gap());

		drain_all();
		send_idle_pct = 0;
		recv_idle_pct = 0;

		set_config('1, '1, '1, REG_W'($urandom()));
		repeat (3) add_pulse($urandom_range(1, 30), idle_gap());

		random_config();
		add_frame(int'(model_cfg.sync_ticks), int'(model_cfg.sync_ticks));

		while (samples_taken != samples_queued) @(posedge clk);
		for (int n = 0; n < 2000 && results_due.size() != 0; n++) @(posedge clk);
		repeat (16) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0d expected results never arrived", results_due.size());
		end
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d of %0d samples taken", samples_taken, samples_queued);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
